[sv/ilspd_pkg.sv]
// Shared types and constants for the inductor line steering PD block.
`default_nettype none
package ilspd_pkg;

  localparam int unsigned FIELD_W   = 16;
  localparam int unsigned ERR_W     = 8;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_W     = 16;
  localparam int unsigned BASE_W    = 15;
  // divider dividend width: covers 5*wsum at 16-bit samples and |L-R|*100
  localparam int unsigned DIVD_W    = 23;
  localparam int unsigned DIV_CNT_W = 5;

  localparam logic [CFG_IDX_W-1:0] CFG_LEFT_FS  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MID_FS   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RIGHT_FS = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PROP     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DERIV    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_BASE     = 3'd5;

  typedef struct packed {
    logic [FIELD_W-1:0] left_sample;
    logic [FIELD_W-1:0] mid_sample;
    logic [FIELD_W-1:0] right_sample;
  } in_item_t;

  typedef struct packed {
    logic        [FIELD_W-1:0] left_level;
    logic        [FIELD_W-1:0] mid_level;
    logic        [FIELD_W-1:0] right_level;
    logic signed [ERR_W-1:0]   steer_error;
    logic signed [FIELD_W-1:0] steer_drive;
    logic signed [FIELD_W-1:0] motor_front_pair;
    logic signed [FIELD_W-1:0] motor_rear_pair;
    logic                      zero_sum_flag;
  } out_item_t;

  // clamp an 18-bit signed value to the signed 16-bit range
  function automatic logic signed [FIELD_W-1:0] sat16(input logic signed [17:0] v);
    logic signed [FIELD_W-1:0] r;
    if (v > 18'sd32767) begin
      r = 16'sh7FFF;
    end else if (v < -18'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = v[FIELD_W-1:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

[sv/ilspd_if.sv]
// Valid/ready channel interfaces for sample items and result items.
`default_nettype none
interface ilspd_in_if;
  logic                 valid;
  logic                 ready;
  ilspd_pkg::in_item_t  data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface ilspd_out_if;
  logic                 valid;
  logic                 ready;
  ilspd_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

[sv/inductor_line_steering_pd.sv]
// Three-channel inductor filter, steering error and PD motor mix on one shared divider.
// Sequence from input accept to out valid: a setup state and a restoring division for each
//   of three levels and the error, then two multiply, one drive and one output state.
//   Each zero full scale or zero level sum skips its division.
// One item at a time: the next item is taken after the result loads; the load waits on out ready.
// Reset (synchronous, rst_n low): clear histories, previous error and control; load config defaults.
`default_nettype none
module inductor_line_steering_pd #(
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  wire                               clk,
  input  wire                               rst_n,
  ilspd_in_if.sink                          in_if,
  ilspd_out_if.source                       out_if,
  input  wire                               cfg_we,
  input  wire [ilspd_pkg::CFG_IDX_W-1:0]    cfg_idx,
  input  wire [ilspd_pkg::CFG_W-1:0]        cfg_data
);

  localparam int unsigned FW    = ilspd_pkg::FIELD_W;
  localparam int unsigned WS_W  = SAMPLE_BITS + 5;
  localparam int unsigned DW    = ilspd_pkg::DIVD_W;
  localparam int unsigned CW    = ilspd_pkg::DIV_CNT_W;
  localparam int unsigned ACC_W = 26;
  localparam logic [1:0]  CH_RIGHT = 2'd2;
  localparam logic [1:0]  CH_ERR   = 2'd3;

  typedef enum logic [2:0] {
    S_IDLE, S_LVL_START, S_ERR_START, S_DIV, S_MUL1, S_MUL2, S_DRV, S_OUT
  } state_t;

  state_t state_r;

  // configuration
  logic        [FW-1:0]                  full_r [3];
  logic signed [FW-1:0]                  prop_gain_r;
  logic signed [FW-1:0]                  deriv_gain_r;
  logic        [ilspd_pkg::BASE_W-1:0]   base_speed_r;

  // per-item state
  logic [SAMPLE_BITS-1:0] hist_r [3][4];
  logic [WS_W-1:0]        wsum_r [3];
  logic [FW-1:0]          lvl_r  [3];
  logic [1:0]             ch_r;
  logic signed [ilspd_pkg::ERR_W-1:0] err_r;
  logic signed [ilspd_pkg::ERR_W-1:0] prev_r;
  logic                   zero_r;
  logic                   neg_r;
  logic signed [ACC_W-1:0] acc_r;
  logic signed [FW-1:0]   drive_r;

  // shared divider
  logic [DW-1:0] dvd_r;
  logic [FW:0]   rem_r;
  logic [FW:0]   dsr_r;
  logic [CW-1:0] cnt_r;

  logic                  out_valid_r;
  ilspd_pkg::out_item_t  out_r;

  // ---------------- combinational helpers ----------------
  logic [SAMPLE_BITS-1:0] cur   [3];
  logic [WS_W-1:0]        wsum_new [3];
  logic [1:0]             ch_idx;
  logic [DW-1:0]          lvl_dvd;
  logic [FW:0]            lvl_sum;
  logic [FW-1:0]          lvl_diff;
  logic [DW-1:0]          err_dvd;
  logic [FW+1:0]          rem_sh;
  logic                   q_bit;
  logic [FW:0]            rem_nxt;
  logic [DW-1:0]          dvd_nxt;
  logic [FW-1:0]          lvl_q;
  logic signed [ilspd_pkg::ERR_W-1:0] err_q;
  logic signed [FW-1:0]   mul_a;
  logic signed [8:0]      mul_b;
  logic signed [24:0]     prod;
  logic signed [ACC_W-1:0] acc_adj;
  logic signed [ACC_W-1:0] acc_div;
  logic signed [FW-1:0]   drive_nxt;
  logic signed [17:0]     base_s;
  logic signed [17:0]     plus_s;
  logic signed [17:0]     minus_s;
  logic signed [FW-1:0]   front_nxt;
  logic signed [FW-1:0]   rear_nxt;

  assign cur[0] = in_if.data.left_sample[SAMPLE_BITS-1:0];
  assign cur[1] = in_if.data.mid_sample[SAMPLE_BITS-1:0];
  assign cur[2] = in_if.data.right_sample[SAMPLE_BITS-1:0];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      wsum_new[c] = WS_W'(hist_r[c][0]) + WS_W'(hist_r[c][1])
                  + (WS_W'(hist_r[c][2]) << 1) + (WS_W'(hist_r[c][3]) << 1)
                  + (WS_W'(cur[c]) << 4);
    end
  end

  assign ch_idx   = (ch_r == CH_ERR) ? CH_RIGHT : ch_r;
  assign lvl_dvd  = DW'(wsum_r[ch_idx]) + (DW'(wsum_r[ch_idx]) << 2);
  assign lvl_sum  = (FW+1)'(lvl_r[0]) + (FW+1)'(lvl_r[2]);
  assign lvl_diff = (lvl_r[2] > lvl_r[0]) ? lvl_r[2] - lvl_r[0] : lvl_r[0] - lvl_r[2];
  assign err_dvd  = (DW'(lvl_diff) << 6) + (DW'(lvl_diff) << 5) + (DW'(lvl_diff) << 2);

  // one restoring step: one quotient bit per cycle
  assign rem_sh  = {rem_r, dvd_r[DW-1]};
  assign q_bit   = (rem_sh >= {1'b0, dsr_r});
  assign rem_nxt = q_bit ? (FW+1)'(rem_sh - {1'b0, dsr_r}) : rem_sh[FW:0];
  assign dvd_nxt = {dvd_r[DW-2:0], q_bit};

  assign lvl_q = (|dvd_nxt[DW-1:FW]) ? {FW{1'b1}} : dvd_nxt[FW-1:0];
  assign err_q = neg_r ? -$signed({1'b0, dvd_nxt[6:0]}) : $signed({1'b0, dvd_nxt[6:0]});

  // shared multiplier: proportional term, then derivative term
  assign mul_a = (state_r == S_MUL1) ? prop_gain_r : deriv_gain_r;
  assign mul_b = (state_r == S_MUL1) ? 9'(err_r) : 9'(err_r) - 9'(prev_r);
  assign prod  = mul_a * mul_b;

  // divide by 256 truncating toward zero
  assign acc_adj = acc_r + (acc_r[ACC_W-1] ? ACC_W'(255) : ACC_W'(0));
  assign acc_div = acc_adj >>> 8;
  always_comb begin
    if (acc_div > ACC_W'(32767)) begin
      drive_nxt = 16'sh7FFF;
    end else if (acc_div < -ACC_W'(32768)) begin
      drive_nxt = 16'sh8000;
    end else begin
      drive_nxt = acc_div[FW-1:0];
    end
  end

  assign base_s  = $signed({3'b000, base_speed_r});
  assign plus_s  = base_s + 18'(drive_r);
  assign minus_s = base_s - 18'(drive_r);

  always_comb begin
    if (lvl_r[0] < lvl_r[2]) begin
      front_nxt = ilspd_pkg::sat16(plus_s);
      rear_nxt  = ilspd_pkg::sat16(minus_s);
    end else if (lvl_r[0] > lvl_r[2]) begin
      front_nxt = ilspd_pkg::sat16(minus_s);
      rear_nxt  = ilspd_pkg::sat16(plus_s);
    end else begin
      front_nxt = base_s[FW-1:0];
      rear_nxt  = base_s[FW-1:0];
    end
  end

  // ---------------- configuration ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      full_r[0]    <= 16'hFFFF;
      full_r[1]    <= 16'hFFFF;
      full_r[2]    <= 16'hFFFF;
      prop_gain_r  <= 16'sd256;
      deriv_gain_r <= 16'sd0;
      base_speed_r <= 15'd500;
    end else if (cfg_we) begin
      case (cfg_idx)
        ilspd_pkg::CFG_LEFT_FS:  full_r[0]    <= cfg_data;
        ilspd_pkg::CFG_MID_FS:   full_r[1]    <= cfg_data;
        ilspd_pkg::CFG_RIGHT_FS: full_r[2]    <= cfg_data;
        ilspd_pkg::CFG_PROP:     prop_gain_r  <= $signed(cfg_data);
        ilspd_pkg::CFG_DERIV:    deriv_gain_r <= $signed(cfg_data);
        ilspd_pkg::CFG_BASE:     base_speed_r <= cfg_data[ilspd_pkg::BASE_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------- sequencer ----------------
  assign in_if.ready  = (state_r == S_IDLE);
  assign out_if.valid = out_valid_r;
  assign out_if.data  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      prev_r      <= '0;
      ch_r        <= '0;
      cnt_r       <= '0;
      for (int c = 0; c < 3; c++) begin
        for (int i = 0; i < 4; i++) begin
          hist_r[c][i] <= '0;
        end
      end
    end else begin
      // S_OUT reloads the result register itself
      if (out_valid_r && out_if.ready && state_r != S_OUT) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_if.valid) begin
            for (int c = 0; c < 3; c++) begin
              wsum_r[c] <= wsum_new[c];
              for (int i = 0; i < 3; i++) begin
                hist_r[c][i] <= hist_r[c][i+1];
              end
              hist_r[c][3] <= cur[c];
            end
            ch_r    <= '0;
            state_r <= S_LVL_START;
          end
        end
        S_LVL_START: begin
          if (full_r[ch_idx] == '0) begin
            // zero full scale: level saturates
            lvl_r[ch_idx] <= {FW{1'b1}};
            ch_r          <= ch_r + 2'd1;
            if (ch_r == CH_RIGHT) begin
              state_r <= S_ERR_START;
            end
          end else begin
            dvd_r   <= lvl_dvd;
            rem_r   <= '0;
            dsr_r   <= {1'b0, full_r[ch_idx]};
            cnt_r   <= '0;
            state_r <= S_DIV;
          end
        end
        S_ERR_START: begin
          ch_r <= CH_ERR;
          if (lvl_sum == '0) begin
            err_r   <= '0;
            zero_r  <= 1'b1;
            state_r <= S_MUL1;
          end else begin
            zero_r  <= 1'b0;
            neg_r   <= (lvl_r[2] > lvl_r[0]);
            dvd_r   <= err_dvd;
            rem_r   <= '0;
            dsr_r   <= lvl_sum;
            cnt_r   <= '0;
            state_r <= S_DIV;
          end
        end
        S_DIV: begin
          dvd_r <= dvd_nxt;
          rem_r <= rem_nxt;
          cnt_r <= cnt_r + CW'(1);
          if (cnt_r == CW'(DW - 1)) begin
            if (ch_r == CH_ERR) begin
              err_r   <= err_q;
              state_r <= S_MUL1;
            end else begin
              lvl_r[ch_idx] <= lvl_q;
              ch_r          <= ch_r + 2'd1;
              state_r       <= (ch_r == CH_RIGHT) ? S_ERR_START : S_LVL_START;
            end
          end
        end
        S_MUL1: begin
          acc_r   <= ACC_W'(prod);
          state_r <= S_MUL2;
        end
        S_MUL2: begin
          acc_r   <= acc_r + ACC_W'(prod);
          state_r <= S_DRV;
        end
        S_DRV: begin
          drive_r <= drive_nxt;
          prev_r  <= err_r;
          state_r <= S_OUT;
        end
        S_OUT: begin
          // hold until the result register is free
          if (!out_valid_r || out_if.ready) begin
            out_r.left_level       <= lvl_r[0];
            out_r.mid_level        <= lvl_r[1];
            out_r.right_level      <= lvl_r[2];
            out_r.steer_error      <= err_r;
            out_r.steer_drive      <= drive_r;
            out_r.motor_front_pair <= front_nxt;
            out_r.motor_rear_pair  <= rear_nxt;
            out_r.zero_sum_flag    <= zero_r;
            out_valid_r            <= 1'b1;
            state_r                <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

[sv/ilspd_checker.sv]
// Port-level assertions for the steering block and their bind.
`default_nettype none
module ilspd_checker (
  input wire                       clk,
  input wire                       rst_n,
  input wire                       in_valid,
  input wire                       in_ready,
  input wire                       out_valid,
  input wire                       out_ready,
  input wire ilspd_pkg::out_item_t out_data
);

  // error stays within plus or minus one hundred percent
  a_err_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.steer_error >= -8'sd100 && out_data.steer_error <= 8'sd100))
    else $error("steer_error out of range");

  // zero level sum forces zero error
  a_zero_err: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.zero_sum_flag) |-> (out_data.steer_error == 8'sd0))
    else $error("zero sum with nonzero error");

  // equal side levels drive both pairs alike
  a_equal_motor: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.left_level == out_data.right_level)
      |-> (out_data.motor_front_pair == out_data.motor_rear_pair))
    else $error("motor pairs differ at equal levels");

  // one item at a time: input closes right after an accept
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input ready after accept");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
    else $error("stalled result changed");

endmodule

bind inductor_line_steering_pd ilspd_checker u_ilspd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_if.valid),
  .in_ready  (in_if.ready),
  .out_valid (out_if.valid),
  .out_ready (out_if.ready),
  .out_data  (out_if.data)
);
`default_nettype wire
